// File: sv/sps_pkg.sv
// Shared types, constants and coil tables for the stepper phase sequencer.
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

    // Field widths
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned ANGLE_W   = 10;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned HOLD_W    = 8;
    localparam int unsigned COIL_W    = 4;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned CYCLES_W  = 11;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 8;
    localparam int unsigned CFG_ADDR_W = 1;

    localparam int unsigned MAX_ANGLE_DEG = 1023;

    // cycles = (64*a + 44) / 45, done as x * ceil(2^23/45) >> 23 (exact for x < 2^17)
    localparam int unsigned CYC_SCALE_W = 6;
    localparam int unsigned CYC_X_W     = ANGLE_W + CYC_SCALE_W + 1;
    localparam int unsigned CYC_ROUND   = 44;
    localparam int unsigned RECIP_SHIFT = 23;
    localparam int unsigned RECIP_MUL   = 186414;
    localparam int unsigned RECIP_W     = 18;
    localparam int unsigned PROD_W      = CYC_X_W + RECIP_W;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // Step modes
    localparam logic [MODE_W-1:0] MODE_HALF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WAVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TWO  = 2'd2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_MODE  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS = 1'd1;

    localparam logic [MODE_W-1:0] STEP_MODE_RST  = MODE_HALF;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 8'd2;
    localparam logic [COIL_W-1:0] COILS_OFF      = 4'hF;

    // Coil tables, ascending order, bit3..bit0 = D C B A, active low
    localparam logic [COIL_W-1:0] HALF_TAB [8] =
        '{4'hE, 4'hC, 4'hD, 4'h9, 4'hB, 4'h3, 4'h7, 4'h6};
    localparam logic [COIL_W-1:0] WAVE_TAB [4] = '{4'hE, 4'hD, 4'hB, 4'h7};
    localparam logic [COIL_W-1:0] TWO_TAB  [4] = '{4'h6, 4'hC, 4'h9, 4'h3};

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               direction;
        logic [ANGLE_W-1:0] angle_deg;
    } item_t;

    typedef struct packed {
        logic              rejected;
        logic              move_done;
        logic              busy_res;
        logic [COIL_W-1:0] coil_lines;
    } result_t;

    // Pattern at play position pos; descending play mirrors the table.
    function automatic logic [COIL_W-1:0] coil_lookup(
        input logic [MODE_W-1:0]  mode,
        input logic               dir,
        input logic [PHASE_W-1:0] pos
    );
        logic [PHASE_W-1:0] idx;
        logic [COIL_W-1:0]  pat;
        idx = dir ? pos : ~pos;
        case (mode)
            MODE_HALF: pat = HALF_TAB[idx];
            MODE_WAVE: pat = WAVE_TAB[idx[1:0]];
            default:   pat = TWO_TAB[idx[1:0]];
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// File: sv/stepper_phase_sequencer.sv
// Top level of the unipolar stepper phase sequencer.
//
// Usage:
//   Input stream (s_*): one request per command. s_tuser carries the command
//   (tick, start, stop); s_tdata carries direction and angle for a start.
//   Output stream (m_*): exactly one result per request, in order: coil line
//   levels (active low), busy, move-done and rejected flags.
//   Config port (cfg_*): step_mode (index 0) and step_hold_ticks (index 1),
//   written on any clock with cfg_we high; write only while idle.
// Pipeline: a request passes through two stages, the input register and then
//   the result register.
// Throughput: one request per cycle sustained while m_tready is high. The
//   whole state update (cycle-count multiply, counters, pattern table) fits
//   between the two registers, so back-to-back requests are taken.
// Stall: if m_tready is low the result register holds; one more request can
//   wait in the input register, then s_tready drops until the output drains.
// Reset (aresetn low, synchronous): both stages empty, coils all released
//   (4'hF), move idle, step_mode = half-step, step_hold_ticks = 2.
`timescale 1ns / 1ps
`default_nettype none

module stepper_phase_sequencer #(
    parameter int unsigned MAX_ANGLE_DEG = sps_pkg::MAX_ANGLE_DEG
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [0] direction, [10:1] angle_deg, [15:11] zero
    input  wire logic [sps_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] cmd
    input  wire logic [sps_pkg::CMD_W-1:0]         s_tuser,
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [3:0] coil_lines, [4] busy_res, [5] move_done, [6] rejected, [7] zero
    output logic      [sps_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [sps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [sps_pkg::HOLD_W-1:0]        cfg_wdata
);

    logic                        in_valid_reg;
    sps_pkg::item_t              item_reg;
    logic                        out_valid_reg;
    sps_pkg::result_t            res_reg;
    sps_pkg::result_t            res_next;
    logic [sps_pkg::MODE_W-1:0]  step_mode_reg;
    logic [sps_pkg::HOLD_W-1:0]  hold_ticks_reg;
    logic                        advance;
    logic                        exec;

    // Output stage frees when empty or taken; input stage frees when it moves on.
    assign advance  = !out_valid_reg || m_tready;
    assign exec     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_mode_reg  <= sps_pkg::STEP_MODE_RST;
            hold_ticks_reg <= sps_pkg::HOLD_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                sps_pkg::REG_STEP_MODE:  step_mode_reg  <= cfg_wdata[sps_pkg::MODE_W-1:0];
                sps_pkg::REG_HOLD_TICKS: hold_ticks_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd       <= s_tuser;
            item_reg.direction <= s_tdata[0];
            item_reg.angle_deg <= s_tdata[sps_pkg::ANGLE_W:1];
        end
    end

    sps_core #(
        .MAX_ANGLE_DEG(MAX_ANGLE_DEG)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .exec           (exec),
        .item           (item_reg),
        .step_mode      (step_mode_reg),
        .step_hold_ticks(hold_ticks_reg),
        .result         (res_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sps_pkg::M_TDATA_W'(res_reg);

endmodule

`default_nettype wire

// File: sv/sps_cycle_count.sv
// Angle to sequence-cycle count: ceil(64*angle/45) by reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module sps_cycle_count #(
    parameter int unsigned MAX_ANGLE_DEG = sps_pkg::MAX_ANGLE_DEG
) (
    input  wire logic [sps_pkg::ANGLE_W-1:0]  angle_deg,
    output logic      [sps_pkg::CYCLES_W-1:0] cycles
);

    localparam int unsigned ANGLE_MAX = (2 ** sps_pkg::ANGLE_W) - 1;
    localparam logic [sps_pkg::ANGLE_W-1:0] ANGLE_CAP =
        (MAX_ANGLE_DEG > ANGLE_MAX) ? sps_pkg::ANGLE_W'(ANGLE_MAX)
                                    : sps_pkg::ANGLE_W'(MAX_ANGLE_DEG);

    logic [sps_pkg::ANGLE_W-1:0] angle_sat;
    logic [sps_pkg::CYC_X_W-1:0] numer;
    logic [sps_pkg::PROD_W-1:0]  prod;

    always_comb begin
        angle_sat = (angle_deg > ANGLE_CAP) ? ANGLE_CAP : angle_deg;
        numer = {1'b0, angle_sat, {sps_pkg::CYC_SCALE_W{1'b0}}}
              + sps_pkg::CYC_X_W'(sps_pkg::CYC_ROUND);
        prod = sps_pkg::PROD_W'(numer) * sps_pkg::PROD_W'(sps_pkg::RECIP_MUL);
        cycles = prod[sps_pkg::RECIP_SHIFT +: sps_pkg::CYCLES_W];
    end

endmodule

`default_nettype wire

// File: sv/sps_core.sv
// Move state and per-item update: coil pattern, phase, cycle and hold counters.
`timescale 1ns / 1ps
`default_nettype none

module sps_core #(
    parameter int unsigned MAX_ANGLE_DEG = sps_pkg::MAX_ANGLE_DEG
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        exec,
    input  wire sps_pkg::item_t              item,
    input  wire logic [sps_pkg::MODE_W-1:0]  step_mode,
    input  wire logic [sps_pkg::HOLD_W-1:0]  step_hold_ticks,
    output sps_pkg::result_t                 result
);

    logic [sps_pkg::COIL_W-1:0]   coil_reg,   coil_next;
    logic [sps_pkg::PHASE_W-1:0]  phase_reg,  phase_next;
    logic [sps_pkg::CYCLES_W-1:0] cycles_reg, cycles_next;
    logic [sps_pkg::HOLD_W-1:0]   hold_reg,   hold_next;
    logic                         moving_reg, moving_next;
    logic                         dir_reg,    dir_next;

    logic [sps_pkg::CYCLES_W-1:0] start_cycles;
    logic [sps_pkg::PHASE_W:0]    n_pat;
    logic [sps_pkg::PHASE_W:0]    next_pos;
    logic [sps_pkg::HOLD_W-1:0]   eff_hold;
    logic [sps_pkg::HOLD_W-1:0]   hold_dec;
    logic [sps_pkg::CYCLES_W-1:0] cyc_dec;
    logic                         finished;
    logic                         done;
    logic                         rej;

    sps_cycle_count #(
        .MAX_ANGLE_DEG(MAX_ANGLE_DEG)
    ) u_cycle_count (
        .angle_deg(item.angle_deg),
        .cycles   (start_cycles)
    );

    always_comb begin
        case (step_mode)
            sps_pkg::MODE_HALF: n_pat = (sps_pkg::PHASE_W+1)'(8);
            sps_pkg::MODE_WAVE: n_pat = (sps_pkg::PHASE_W+1)'(4);
            sps_pkg::MODE_TWO:  n_pat = (sps_pkg::PHASE_W+1)'(4);
            default:            n_pat = '0;
        endcase
        eff_hold = (step_hold_ticks == '0) ? sps_pkg::HOLD_W'(1) : step_hold_ticks;

        coil_next   = coil_reg;
        phase_next  = phase_reg;
        cycles_next = cycles_reg;
        hold_next   = hold_reg;
        moving_next = moving_reg;
        dir_next    = dir_reg;
        done        = 1'b0;
        rej         = 1'b0;
        hold_dec    = '0;
        cyc_dec     = cycles_reg;
        next_pos    = '0;
        finished    = 1'b0;

        case (item.cmd)
            sps_pkg::CMD_START: begin
                if (moving_reg) begin
                    rej = 1'b1;
                end else if (n_pat == '0 || start_cycles == '0) begin
                    done = 1'b1;
                end else begin
                    dir_next    = item.direction;
                    moving_next = 1'b1;
                    cycles_next = start_cycles;
                    phase_next  = '0;
                    hold_next   = eff_hold;
                    coil_next   = sps_pkg::coil_lookup(step_mode, item.direction, '0);
                end
            end
            sps_pkg::CMD_STOP: begin
                coil_next   = sps_pkg::COILS_OFF;
                moving_next = 1'b0;
                phase_next  = '0;
                cycles_next = '0;
                hold_next   = '0;
            end
            sps_pkg::CMD_TICK: begin
                if (moving_reg) begin
                    hold_dec  = (hold_reg != '0) ? hold_reg - 1'b1 : '0;
                    hold_next = hold_dec;
                    if (hold_dec == '0) begin
                        next_pos = {1'b0, phase_reg} + 1'b1;
                        if (n_pat == '0) begin
                            finished = 1'b1;
                        end else if (next_pos >= n_pat) begin
                            // end of a sequence cycle
                            cyc_dec = (cycles_reg != '0) ? cycles_reg - 1'b1 : '0;
                            cycles_next = cyc_dec;
                            if (cyc_dec == '0) begin
                                finished = 1'b1;
                            end else begin
                                next_pos = '0;
                            end
                        end
                        if (finished) begin
                            moving_next = 1'b0;
                            phase_next  = '0;
                            cycles_next = '0;
                            hold_next   = '0;
                            done        = 1'b1;
                        end else begin
                            phase_next = next_pos[sps_pkg::PHASE_W-1:0];
                            hold_next  = eff_hold;
                            coil_next  = sps_pkg::coil_lookup(step_mode, dir_reg,
                                             next_pos[sps_pkg::PHASE_W-1:0]);
                        end
                    end
                end
            end
            default: begin
                // unused command: state shown as is
            end
        endcase

        result.coil_lines = coil_next;
        result.busy_res   = moving_next;
        result.move_done  = done;
        result.rejected   = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coil_reg   <= sps_pkg::COILS_OFF;
            phase_reg  <= '0;
            cycles_reg <= '0;
            hold_reg   <= '0;
            moving_reg <= 1'b0;
            dir_reg    <= 1'b0;
        end else if (exec) begin
            coil_reg   <= coil_next;
            phase_reg  <= phase_next;
            cycles_reg <= cycles_next;
            hold_reg   <= hold_next;
            moving_reg <= moving_next;
            dir_reg    <= dir_next;
        end
    end

endmodule

`default_nettype wire
